// File: design/assert_macros.svh
// Assertion macros shared by the queue RTL.
// Clock and active-low reset are passed in; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every enabled clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lqs_pkg.sv
// Shared types and constants for the linear queue with search.
// No dependencies; used by every module of the block but lqs_ram.
`timescale 1ns / 1ps
`default_nettype none

package lqs_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = 5;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_FIND   = 3'd2,
    KIND_READ   = 3'd3,
    KIND_COUNT  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_EXEC     = 3'd1,
    S_RDATA    = 3'd2,
    S_SCAN_RD  = 3'd3,
    S_SCAN_CMP = 3'd4,
    S_FIN      = 3'd5
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
  } match_ctl_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] item;
    logic [IDX_W-1:0]         slot;
    logic [IDX_W-1:0]         match_cnt;
    logic [IDX_W-1:0]         occupancy;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

// File: design/lqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/lqs_match.sv
// Shared compare unit: one word compare against the search key and a match counter.
// Depends on lqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lqs_match (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lqs_pkg::match_ctl_t               ctl,
  input  wire logic [lqs_pkg::DATA_W-1:0]        rd_data,
  input  wire logic signed [lqs_pkg::DATA_W-1:0] key,
  output logic                                   hit,
  output logic [lqs_pkg::IDX_W-1:0]              count
);

  logic [lqs_pkg::IDX_W-1:0] count_r;
  logic [lqs_pkg::IDX_W-1:0] count_nxt;

  assign hit = (rd_data == key);

  always_comb begin
    count_nxt = count_r;
    if (ctl.clr) begin
      count_nxt = '0;
    end else if (ctl.en && hit) begin
      count_nxt = count_r + lqs_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

`default_nettype wire

// File: design/lqs_seq.sv
// Sequencer: head and tail pointers, slot scan and result building.
// Depends on lqs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lqs_seq (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_fire,
  input  wire lqs_pkg::kind_t                    in_kind,
  input  wire logic signed [lqs_pkg::DATA_W-1:0] in_value,
  input  wire logic [lqs_pkg::IDX_W-1:0]         in_pos,
  output logic                                   in_ready,
  input  wire logic                              can_load,
  output logic                                   emit,
  output lqs_pkg::res_t                          res,
  output logic                                   wr_en,
  output logic [lqs_pkg::ADDR_W-1:0]             wr_addr,
  output logic                                   rd_en,
  output logic [lqs_pkg::ADDR_W-1:0]             rd_addr,
  input  wire logic [lqs_pkg::DATA_W-1:0]        rd_data,
  output lqs_pkg::match_ctl_t                    mctl,
  output logic signed [lqs_pkg::DATA_W-1:0]      key,
  input  wire logic                              hit,
  input  wire logic [lqs_pkg::IDX_W-1:0]         count
);

  lqs_pkg::state_t                  state_r, state_nxt;
  logic [lqs_pkg::IDX_W-1:0]        head_r, head_nxt;
  logic [lqs_pkg::IDX_W-1:0]        tail_r, tail_nxt;
  logic [lqs_pkg::IDX_W-1:0]        scan_r, scan_nxt;
  logic                             pend_vld_r, pend_vld_nxt;
  logic [lqs_pkg::IDX_W-1:0]        pend_slot_r, pend_slot_nxt;
  lqs_pkg::kind_t                   kind_r;
  logic signed [lqs_pkg::DATA_W-1:0] value_r;
  logic [lqs_pkg::IDX_W-1:0]        pos_r;

  logic                             full;
  logic                             empty;
  logic                             pos_ok;
  logic                             last_scan;
  logic                             scan_stall;
  logic [lqs_pkg::IDX_W-1:0]        scan_m1;
  logic [lqs_pkg::IDX_W-1:0]        pos_m1;

  assign full       = (tail_r == lqs_pkg::IDX_W'(lqs_pkg::DEPTH));
  assign empty      = (head_r == tail_r);
  assign pos_ok     = (pos_r > head_r) && (pos_r <= tail_r);
  assign last_scan  = (scan_r == tail_r);
  assign scan_stall = (kind_r == lqs_pkg::KIND_FIND) && hit && pend_vld_r && !can_load;
  assign scan_m1    = scan_r - lqs_pkg::IDX_W'(1);
  assign pos_m1     = pos_r - lqs_pkg::IDX_W'(1);
  assign in_ready   = (state_r == lqs_pkg::S_IDLE);
  assign key        = value_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lqs_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = lqs_pkg::S_EXEC;
        end
      end
      lqs_pkg::S_EXEC: begin
        case (kind_r)
          lqs_pkg::KIND_INSERT: begin
            if (can_load) begin
              state_nxt = lqs_pkg::S_IDLE;
            end
          end
          lqs_pkg::KIND_REMOVE: begin
            if (!empty) begin
              state_nxt = lqs_pkg::S_RDATA;
            end else if (can_load) begin
              state_nxt = lqs_pkg::S_IDLE;
            end
          end
          lqs_pkg::KIND_READ: begin
            if (pos_ok) begin
              state_nxt = lqs_pkg::S_RDATA;
            end else if (can_load) begin
              state_nxt = lqs_pkg::S_IDLE;
            end
          end
          lqs_pkg::KIND_FIND, lqs_pkg::KIND_COUNT: begin
            state_nxt = empty ? lqs_pkg::S_FIN : lqs_pkg::S_SCAN_RD;
          end
          default: begin
            state_nxt = lqs_pkg::S_IDLE;
          end
        endcase
      end
      lqs_pkg::S_RDATA: begin
        if (can_load) begin
          state_nxt = lqs_pkg::S_IDLE;
        end
      end
      lqs_pkg::S_SCAN_RD: begin
        state_nxt = lqs_pkg::S_SCAN_CMP;
      end
      lqs_pkg::S_SCAN_CMP: begin
        if (!scan_stall) begin
          state_nxt = last_scan ? lqs_pkg::S_FIN : lqs_pkg::S_SCAN_RD;
        end
      end
      lqs_pkg::S_FIN: begin
        if (can_load) begin
          state_nxt = lqs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lqs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    emit          = 1'b0;
    res           = '0;
    res.status    = lqs_pkg::ST_OK;
    res.last      = 1'b1;
    wr_en         = 1'b0;
    wr_addr       = tail_r[lqs_pkg::ADDR_W-1:0];
    rd_en         = 1'b0;
    rd_addr       = head_r[lqs_pkg::ADDR_W-1:0];
    mctl          = '0;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    scan_nxt      = scan_r;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    case (state_r)
      lqs_pkg::S_EXEC: begin
        case (kind_r)
          lqs_pkg::KIND_INSERT: begin
            if (can_load) begin
              emit = 1'b1;
              if (full) begin
                res.status = lqs_pkg::ST_FULL;
              end else begin
                wr_en    = 1'b1;
                tail_nxt = tail_r + lqs_pkg::IDX_W'(1);
              end
            end
          end
          lqs_pkg::KIND_REMOVE: begin
            if (!empty) begin
              rd_en = 1'b1;
            end else if (can_load) begin
              emit       = 1'b1;
              res.status = lqs_pkg::ST_EMPTY;
            end
          end
          lqs_pkg::KIND_READ: begin
            rd_addr = pos_m1[lqs_pkg::ADDR_W-1:0];
            if (pos_ok) begin
              rd_en = 1'b1;
            end else if (can_load) begin
              emit       = 1'b1;
              res.status = lqs_pkg::ST_BAD_POS;
            end
          end
          lqs_pkg::KIND_FIND, lqs_pkg::KIND_COUNT: begin
            mctl.clr     = 1'b1;
            pend_vld_nxt = 1'b0;
            scan_nxt     = head_r + lqs_pkg::IDX_W'(1);
          end
          default: begin
          end
        endcase
      end
      lqs_pkg::S_RDATA: begin
        if (can_load) begin
          emit     = 1'b1;
          res.item = rd_data;
          if (kind_r == lqs_pkg::KIND_REMOVE) begin
            head_nxt = head_r + lqs_pkg::IDX_W'(1);
          end
        end
      end
      lqs_pkg::S_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = scan_m1[lqs_pkg::ADDR_W-1:0];
      end
      lqs_pkg::S_SCAN_CMP: begin
        if (!scan_stall) begin
          mctl.en  = 1'b1;
          scan_nxt = scan_r + lqs_pkg::IDX_W'(1);
          if ((kind_r == lqs_pkg::KIND_FIND) && hit) begin
            emit          = pend_vld_r;
            res.slot      = pend_slot_r;
            res.last      = 1'b0;
            pend_vld_nxt  = 1'b1;
            pend_slot_nxt = scan_r;
          end
        end
      end
      lqs_pkg::S_FIN: begin
        if (can_load) begin
          emit = 1'b1;
          if (kind_r == lqs_pkg::KIND_COUNT) begin
            res.match_cnt = count;
          end else if (pend_vld_r) begin
            res.slot = pend_slot_r;
          end else begin
            res.status = lqs_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
    res.occupancy = tail_nxt - head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lqs_pkg::S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    pend_slot_r <= pend_slot_nxt;
    if (in_fire) begin
      kind_r  <= in_kind;
      value_r <= in_value;
      pos_r   <= in_pos;
    end
  end

  `ASSERT_ALWAYS(a_head_le_tail, clk, rst_n, head_r <= tail_r, "head passed tail")
  `ASSERT_ALWAYS(a_tail_le_depth, clk, rst_n, tail_r <= lqs_pkg::IDX_W'(lqs_pkg::DEPTH), "tail beyond depth")
  `ASSERT_IMPL(a_emit_room, clk, rst_n, emit, can_load, "result emitted into a full output stage")
  `ASSERT_IMPL(a_scan_live, clk, rst_n, state_r == lqs_pkg::S_SCAN_CMP, (scan_r > head_r) && (scan_r <= tail_r), "scan outside live slots")
  `ASSERT_NEXT(a_fire_exec, clk, rst_n, in_fire, state_r == lqs_pkg::S_EXEC, "accepted transaction not executed")

endmodule

`default_nettype wire

// File: design/linear_queue_with_search.sv
// Linear queue with search: a non-circular array queue of signed words.
// Slots are addressed 1 to DEPTH. Inserts are refused once the tail reaches
// DEPTH, even after removals. Input transactions carry the operation in
// in_tuser (insert, remove, find, read at position, count) and the value and
// position in in_tdata. Each result carries status in out_tuser, item, slot,
// match count and occupancy in out_tdata, and out_tlast on the final result.
// One transaction is handled at a time; in_tready is high only when idle.
// Insert writes at the tail; remove or read performs one RAM read, a rejected
// remove or read none, and find or count reads and compares each live slot
// through the single RAM read port and the shared word comparator. Find
// emits one result per match, or one not-found result. A result sits in an
// output register, so the next transaction is accepted while it waits.
// The sequencer holds a result while the output register waits; none is lost.
// Reset clears head, tail and control state; slot contents are undefined
// until written and are never read before that.
// Depends on lqs_pkg, lqs_seq, lqs_match and lqs_ram.
`timescale 1ns / 1ps
`default_nettype none

module linear_queue_with_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], position[36:32], zero pad
  input  wire logic [2:0]  in_tuser,   // kind[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // item[31:0], slot[36:32], matches_res[41:37],
                                       // occupancy[46:42], zero pad
  output logic [2:0]       out_tuser,  // status[2:0]
  output logic             out_tlast
);

  logic                                   in_fire;
  logic                                   in_ready;
  logic                                   can_load;
  logic                                   emit;
  lqs_pkg::res_t                          res;
  logic                                   wr_en;
  logic [lqs_pkg::ADDR_W-1:0]             wr_addr;
  logic                                   rd_en;
  logic [lqs_pkg::ADDR_W-1:0]             rd_addr;
  logic [lqs_pkg::DATA_W-1:0]             rd_data;
  lqs_pkg::match_ctl_t                    mctl;
  logic signed [lqs_pkg::DATA_W-1:0]      key;
  logic                                   hit;
  logic [lqs_pkg::IDX_W-1:0]              count;

  logic                                   out_vld_r, out_vld_nxt;
  lqs_pkg::res_t                          out_res_r;

  assign in_tready = in_ready;
  assign in_fire   = in_tvalid && in_ready;
  assign can_load  = !out_vld_r || out_tready;

  lqs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_kind  (lqs_pkg::kind_t'(in_tuser)),
    .in_value (in_tdata[31:0]),
    .in_pos   (in_tdata[36:32]),
    .in_ready (in_ready),
    .can_load (can_load),
    .emit     (emit),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .mctl     (mctl),
    .key      (key),
    .hit      (hit),
    .count    (count)
  );

  lqs_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .rd_data (rd_data),
    .key     (key),
    .hit     (hit),
    .count   (count)
  );

  lqs_ram #(
    .WIDTH (lqs_pkg::DATA_W),
    .DEPTH (lqs_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r.occupancy, out_res_r.match_cnt,
                       out_res_r.slot, out_res_r.item};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule

`default_nettype wire
